// File: src/wnps_pkg.sv
// Shared types, codes and constants for the weighted node placement selector.
// No dependencies; every other file of the block imports this package.
package wnps_pkg;

	localparam int DEF_NODE_SLOTS = 64;
	localparam int SLOT_FIELD_W   = 6;
	localparam int MEM_W          = 48;
	localparam int CPU_W          = 24;
	localparam int POD_W          = 10;
	localparam int WEIGHT_W       = 8;
	localparam int SCORE_W        = 14;
	localparam int NUM_W          = 63;
	localparam int QUOT_W         = 15;
	localparam int SUM_W          = 15;
	localparam int CFG_IDX_W      = 2;

	localparam logic [SCORE_W-1:0]  FULL_SCORE   = 14'd10000;
	localparam logic [6:0]          WEIGHT_SCALE = 7'd100;
	localparam logic [POD_W-1:0]    POD_MAX      = 10'd1023;
	localparam logic [WEIGHT_W-1:0] RST_CPU_W    = 8'd10;
	localparam logic [WEIGHT_W-1:0] RST_MEM_W    = 8'd10;
	localparam logic [WEIGHT_W-1:0] RST_POD_W    = 8'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CPU_WEIGHT = 2'd0,
		CFG_MEM_WEIGHT = 2'd1,
		CFG_POD_WEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		RQ_PLACE     = 3'd0,
		RQ_ADD       = 3'd1,
		RQ_REMOVE    = 3'd2,
		RQ_READY     = 3'd3,
		RQ_NOT_READY = 3'd4,
		RQ_SET_USAGE = 3'd5,
		RQ_SCORE_ONE = 3'd6,
		RQ_IGNORED   = 3'd7
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_NODE     = 2'd1,
		STAT_NOT_PRESENT = 2'd2,
		STAT_SLOT_USED   = 2'd3
	} status_t;

	typedef struct packed {
		req_type_t               req_type;
		logic [SLOT_FIELD_W-1:0] node_slot;
		logic [MEM_W-1:0]        mem_amount;
		logic [CPU_W-1:0]        cpu_amount;
		logic [POD_W-1:0]        pod_limit;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [SLOT_FIELD_W-1:0] chosen_slot;
		logic [SCORE_W-1:0]      score;
	} rsp_t;

	typedef struct packed {
		logic [MEM_W-1:0] mem_cap;
		logic [MEM_W-1:0] mem_use;
		logic [CPU_W-1:0] cpu_cap;
		logic [CPU_W-1:0] cpu_use;
		logic [POD_W-1:0] pod_use;
		logic [POD_W-1:0] pod_cap;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_CHECK, S_PEN_MUL, S_PEN_CHK, S_PEN_DIV,
		S_SCORED, S_PICK, S_CHARGE, S_FIN
	} state_t;

	typedef enum logic [1:0] {ADDR_REQ, ADDR_SCAN, ADDR_BEST} addr_sel_t;
	typedef enum logic [1:0] {WR_NONE, WR_ADD, WR_USAGE, WR_CHARGE} wr_kind_t;
	typedef enum logic [2:0] {
		FL_NONE, FL_ADD, FL_REMOVE, FL_READY, FL_NOT_READY
	} flag_op_t;
	typedef enum logic [3:0] {
		RS_HOLD, RS_IGNORED, RS_SLOT_OK, RS_NOT_PRESENT, RS_USED,
		RS_INFEASIBLE, RS_SCORE, RS_NO_NODE, RS_PLACED
	} res_sel_t;

	typedef struct packed {
		logic      load_req;
		logic      rd_en;
		addr_sel_t rd_sel;
		wr_kind_t  wr_kind;
		flag_op_t  flag_op;
		logic      scan_init;
		logic      scan_next;
		logic      pen_load;
		logic      pen_chk;
		logic      pen_step;
		logic      pen_acc;
		logic      best_update;
		res_sel_t  res_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		req_type_t req_type;
		logic      in_range;
		logic      present;
		logic      ready;
		logic      scan_elig;
		logic      scan_last;
		logic      fits;
		logic      pen_done;
		logic      pen_last;
		logic      found;
		logic      out_busy;
	} stat_t;

endpackage

// File: src/wnps_ctrl.sv
// Sequencer of the placement selector: decodes each request and steps the
// datapath through reads, the slot scan, penalty division and write-back.
// Depends on wnps_pkg.
module wnps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  wnps_pkg::stat_t st,
	output wnps_pkg::cmd_t  cmd,
	output logic           busy
);
	import wnps_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (st.req_type)
					RQ_PLACE: state_d = S_SCAN;
					RQ_SET_USAGE, RQ_SCORE_ONE: begin
						state_d = (st.in_range && st.present) ? S_CHECK : S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_SCAN: begin
				if (st.scan_elig) state_d = S_CHECK;
				else if (st.scan_last) state_d = S_PICK;
			end
			S_CHECK: begin
				unique case (st.req_type)
					RQ_SET_USAGE: state_d = S_FIN;
					RQ_SCORE_ONE: state_d = (st.ready && st.fits) ? S_PEN_MUL : S_FIN;
					default: begin
						if (st.fits) state_d = S_PEN_MUL;
						else state_d = st.scan_last ? S_PICK : S_SCAN;
					end
				endcase
			end
			S_PEN_MUL: state_d = S_PEN_CHK;
			S_PEN_CHK: state_d = S_PEN_DIV;
			S_PEN_DIV: begin
				if (st.pen_done) state_d = st.pen_last ? S_SCORED : S_PEN_MUL;
			end
			S_SCORED: begin
				if (st.req_type == RQ_SCORE_ONE) state_d = S_FIN;
				else state_d = st.scan_last ? S_PICK : S_SCAN;
			end
			S_PICK: state_d = st.found ? S_CHARGE : S_FIN;
			S_CHARGE: state_d = S_FIN;
			S_FIN: begin
				if (!st.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = ADDR_REQ;
		cmd.wr_kind = WR_NONE;
		cmd.flag_op = FL_NONE;
		cmd.res_sel = RS_HOLD;
		unique case (state_q)
			S_IDLE: cmd.load_req = req_valid;
			S_DECODE: begin
				unique case (st.req_type)
					RQ_PLACE: cmd.scan_init = 1'b1;
					RQ_IGNORED: cmd.res_sel = RS_IGNORED;
					RQ_ADD: begin
						if (!st.in_range) cmd.res_sel = RS_NOT_PRESENT;
						else if (st.present) cmd.res_sel = RS_USED;
						else begin
							cmd.wr_kind = WR_ADD;
							cmd.flag_op = FL_ADD;
							cmd.res_sel = RS_SLOT_OK;
						end
					end
					default: begin
						if (!st.in_range || !st.present) begin
							cmd.res_sel = RS_NOT_PRESENT;
						end else begin
							unique case (st.req_type)
								RQ_REMOVE: begin
									cmd.flag_op = FL_REMOVE;
									cmd.res_sel = RS_SLOT_OK;
								end
								RQ_READY: begin
									cmd.flag_op = FL_READY;
									cmd.res_sel = RS_SLOT_OK;
								end
								RQ_NOT_READY: begin
									cmd.flag_op = FL_NOT_READY;
									cmd.res_sel = RS_SLOT_OK;
								end
								default: begin
									cmd.rd_en = 1'b1;
									cmd.rd_sel = ADDR_REQ;
								end
							endcase
						end
					end
				endcase
			end
			S_SCAN: begin
				if (st.scan_elig) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ADDR_SCAN;
				end else if (!st.scan_last) begin
					cmd.scan_next = 1'b1;
				end
			end
			S_CHECK: begin
				unique case (st.req_type)
					RQ_SET_USAGE: begin
						cmd.wr_kind = WR_USAGE;
						cmd.res_sel = RS_SLOT_OK;
					end
					RQ_SCORE_ONE: begin
						if (!(st.ready && st.fits)) cmd.res_sel = RS_INFEASIBLE;
					end
					default: begin
						if (!st.fits && !st.scan_last) cmd.scan_next = 1'b1;
					end
				endcase
			end
			S_PEN_MUL: cmd.pen_load = 1'b1;
			S_PEN_CHK: cmd.pen_chk = 1'b1;
			S_PEN_DIV: begin
				if (st.pen_done) cmd.pen_acc = 1'b1;
				else cmd.pen_step = 1'b1;
			end
			S_SCORED: begin
				if (st.req_type == RQ_SCORE_ONE) begin
					cmd.res_sel = RS_SCORE;
				end else begin
					cmd.best_update = 1'b1;
					cmd.scan_next = !st.scan_last;
				end
			end
			S_PICK: begin
				if (st.found) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ADDR_BEST;
				end else begin
					cmd.res_sel = RS_NO_NODE;
				end
			end
			S_CHARGE: begin
				cmd.wr_kind = WR_CHARGE;
				cmd.res_sel = RS_PLACED;
			end
			S_FIN: cmd.out_load = !st.out_busy;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: src/wnps_dp.sv
// Datapath of the placement selector: weight registers, slot flags, the slot
// table memory, the penalty multiplier and shift-subtract divider, best-slot
// tracking and the result register. Depends on wnps_pkg.
module wnps_dp #(
	parameter int NODE_SLOTS = wnps_pkg::DEF_NODE_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [wnps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wnps_pkg::WEIGHT_W-1:0]  cfg_data,
	input  wnps_pkg::req_t                req,
	input  wnps_pkg::cmd_t                cmd,
	output wnps_pkg::stat_t               st,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output wnps_pkg::rsp_t                rsp
);
	import wnps_pkg::*;

	localparam int SW = $clog2(NODE_SLOTS);

	logic [WEIGHT_W-1:0] cpu_w_q, mem_w_q, pod_w_q;
	logic [NODE_SLOTS-1:0] present_q, ready_q;
	entry_t ent_mem_q [NODE_SLOTS];
	entry_t ent_q, wr_data;
	req_t req_q;
	logic [SW-1:0] req_idx, scan_q, best_q, rd_addr, wr_addr;
	logic found_q;
	logic [SCORE_W-1:0] best_score_q, score_w;
	logic [1:0] pen_idx_q;
	logic [NUM_W-1:0] rem_q, trial;
	logic [MEM_W-1:0] cap_q, op_used, op_cap;
	logic [WEIGHT_W-1:0] op_w;
	logic [QUOT_W-1:0] pen_q;
	logic [3:0] bit_q;
	logic pen_done_q;
	logic [SUM_W-1:0] sum_q;
	logic [14:0] w_scaled;
	logic [NUM_W-1:0] product;
	logic [MEM_W:0] mem_need, mem_chg;
	logic [CPU_W:0] cpu_need, cpu_chg;
	logic fit_mem, fit_cpu;
	rsp_t res_q, rsp_q;
	logic rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_w_q <= RST_CPU_W;
			mem_w_q <= RST_MEM_W;
			pod_w_q <= RST_POD_W;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CPU_WEIGHT: cpu_w_q <= cfg_data;
				CFG_MEM_WEIGHT: mem_w_q <= cfg_data;
				CFG_POD_WEIGHT: pod_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
	end

	assign req_idx = SW'(req_q.node_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			ready_q <= '0;
		end else begin
			unique case (cmd.flag_op)
				FL_ADD: begin
					present_q[req_idx] <= 1'b1;
					ready_q[req_idx] <= 1'b0;
				end
				FL_REMOVE: begin
					present_q[req_idx] <= 1'b0;
					ready_q[req_idx] <= 1'b0;
				end
				FL_READY: ready_q[req_idx] <= 1'b1;
				FL_NOT_READY: ready_q[req_idx] <= 1'b0;
				default: ;
			endcase
		end
	end

	// Slot table: one read and one write port, read data registered.
	always_comb begin
		unique case (cmd.rd_sel)
			ADDR_SCAN: rd_addr = scan_q;
			ADDR_BEST: rd_addr = best_q;
			default: rd_addr = req_idx;
		endcase
	end

	assign mem_chg = {1'b0, ent_q.mem_use} + {1'b0, req_q.mem_amount};
	assign cpu_chg = {1'b0, ent_q.cpu_use} + {1'b0, req_q.cpu_amount};

	always_comb begin
		wr_data = ent_q;
		wr_addr = req_idx;
		unique case (cmd.wr_kind)
			WR_ADD: begin
				wr_data.mem_cap = req_q.mem_amount;
				wr_data.cpu_cap = req_q.cpu_amount;
				wr_data.pod_cap = req_q.pod_limit;
				wr_data.mem_use = '0;
				wr_data.cpu_use = '0;
				wr_data.pod_use = '0;
			end
			WR_USAGE: begin
				wr_data.mem_use = req_q.mem_amount;
				wr_data.cpu_use = req_q.cpu_amount;
			end
			WR_CHARGE: begin
				wr_addr = best_q;
				wr_data.mem_use = mem_chg[MEM_W] ? '1 : mem_chg[MEM_W-1:0];
				wr_data.cpu_use = cpu_chg[CPU_W] ? '1 : cpu_chg[CPU_W-1:0];
				if (ent_q.pod_use != POD_MAX) wr_data.pod_use = ent_q.pod_use + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_kind != WR_NONE) ent_mem_q[wr_addr] <= wr_data;
		if (cmd.rd_en) ent_q <= ent_mem_q[rd_addr];
	end

	// Room test: used + amount must not exceed capacity, unless amount is zero.
	assign mem_need = {1'b0, ent_q.mem_use} + {1'b0, req_q.mem_amount};
	assign cpu_need = {1'b0, ent_q.cpu_use} + {1'b0, req_q.cpu_amount};
	assign fit_mem = (req_q.mem_amount == '0) || (mem_need <= {1'b0, ent_q.mem_cap});
	assign fit_cpu = (req_q.cpu_amount == '0) || (cpu_need <= {1'b0, ent_q.cpu_cap});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan_init) begin
			scan_q <= '0;
		end else if (cmd.scan_next) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	// Penalty operands for the current term: memory, then cpu, then pods.
	always_comb begin
		unique case (pen_idx_q)
			2'd0: begin
				op_w = mem_w_q;
				op_used = ent_q.mem_use;
				op_cap = ent_q.mem_cap;
			end
			2'd1: begin
				op_w = cpu_w_q;
				op_used = MEM_W'(ent_q.cpu_use);
				op_cap = MEM_W'(ent_q.cpu_cap);
			end
			default: begin
				op_w = pod_w_q;
				op_used = MEM_W'(ent_q.pod_use);
				op_cap = MEM_W'(ent_q.pod_cap);
			end
		endcase
	end

	assign w_scaled = 15'(op_w) * 15'(WEIGHT_SCALE);
	assign product = NUM_W'(w_scaled) * NUM_W'(op_used);
	assign trial = NUM_W'(cap_q) << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_idx_q <= '0;
			pen_done_q <= 1'b0;
			sum_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.rd_en) begin
				pen_idx_q <= '0;
				sum_q <= '0;
			end
			if (cmd.pen_load) begin
				pen_done_q <= 1'b0;
			end
			if (cmd.pen_chk) begin
				bit_q <= 4'(QUOT_W - 1);
				// A zero capacity gives no penalty; a quotient too large for the
				// divider saturates at once.
				pen_done_q <= (cap_q == '0) || (rem_q >= (NUM_W'(cap_q) << QUOT_W));
			end
			if (cmd.pen_step) begin
				if (bit_q == '0) pen_done_q <= 1'b1;
				else bit_q <= bit_q - 1'b1;
			end
			if (cmd.pen_acc) begin
				pen_idx_q <= pen_idx_q + 1'b1;
				sum_q <= sum_q + ((pen_q > QUOT_W'(FULL_SCORE)) ?
					QUOT_W'(FULL_SCORE) : pen_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pen_load) begin
			rem_q <= product;
			cap_q <= op_cap;
		end
		if (cmd.pen_chk) begin
			if (cap_q == '0) pen_q <= '0;
			else if (rem_q >= (NUM_W'(cap_q) << QUOT_W)) pen_q <= QUOT_W'(FULL_SCORE);
			else pen_q <= '0;
		end
		if (cmd.pen_step && (rem_q >= trial)) begin
			rem_q <= rem_q - trial;
			pen_q[bit_q] <= 1'b1;
		end
	end

	assign score_w = (sum_q >= SUM_W'(FULL_SCORE)) ? '0 :
		SCORE_W'(SUM_W'(FULL_SCORE) - sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_init) begin
			found_q <= 1'b0;
		end else if (cmd.best_update) begin
			found_q <= 1'b1;
		end
	end

	// Strictly greater keeps the lowest slot among equal scores.
	always_ff @(posedge clk) begin
		if (cmd.best_update && (!found_q || score_w > best_score_q)) begin
			best_q <= scan_q;
			best_score_q <= score_w;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.res_sel)
			RS_IGNORED: res_q <= '{STAT_OK, '0, '0};
			RS_SLOT_OK: res_q <= '{STAT_OK, req_q.node_slot, '0};
			RS_NOT_PRESENT: res_q <= '{STAT_NOT_PRESENT, req_q.node_slot, '0};
			RS_USED: res_q <= '{STAT_SLOT_USED, req_q.node_slot, '0};
			RS_INFEASIBLE: res_q <= '{STAT_NO_NODE, req_q.node_slot, '0};
			RS_SCORE: res_q <= '{STAT_OK, req_q.node_slot, score_w};
			RS_NO_NODE: res_q <= '{STAT_NO_NODE, '0, '0};
			RS_PLACED: res_q <= '{STAT_OK, SLOT_FIELD_W'(best_q), best_score_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		st.req_type = req_q.req_type;
		st.in_range = (9'(req_q.node_slot) < 9'(NODE_SLOTS));
		st.present = present_q[req_idx];
		st.ready = ready_q[req_idx];
		st.scan_elig = present_q[scan_q] && ready_q[scan_q];
		st.scan_last = (scan_q == SW'(NODE_SLOTS - 1));
		st.fits = fit_mem && fit_cpu;
		st.pen_done = pen_done_q;
		st.pen_last = (pen_idx_q == 2'd2);
		st.found = found_q;
		st.out_busy = rsp_valid_q && rsp_stall;
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(rsp_valid_q && rsp_stall))
		else $error("result loaded over a word still waiting");
	a_charge_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_kind == WR_CHARGE) |-> found_q)
		else $error("charge without a chosen slot");
	a_three_terms: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.best_update |-> (pen_idx_q == 2'd3))
		else $error("score compared before all penalties summed");
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pen_step |-> !pen_done_q)
		else $error("divider stepped after completion");
`endif

endmodule

// File: src/weighted_node_placement_selector_top.sv
// Top level of the weighted node placement selector.
// Depends on wnps_pkg, wnps_ctrl and wnps_dp.
//
// Usage: a request word enters on req when req_valid is high and req_stall is
// low; one response word leaves on rsp for every request, in order, under
// rsp_valid / rsp_stall. Weights are written through cfg_valid / cfg_index /
// cfg_data; cfg_ready is always high. Index 3 is ignored.
// Requests are handled one at a time; req_stall is high from acceptance until
// the response is loaded into the output register, so a new request can be
// accepted while an earlier response still waits on a stalled receiver.
// Slot management requests are answered from decode; set usage and score one
// first read the slot. A place request walks every slot: a slot that is not
// ready is skipped, each ready slot is read and checked for room, and each
// feasible one gets three penalties, each a multiply, a range check, up to 15
// shift-subtract divider steps and an accumulate, then the best-score compare.
// Decode comes first; pick, charge and hand-off come last; the penalties use a
// single shared divider. Reset clears every slot flag and restores the default
// weights; the slot table needs no clearing since only added slots are read.
module weighted_node_placement_selector_top #(
	parameter int NODE_SLOTS = wnps_pkg::DEF_NODE_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  wnps_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output wnps_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wnps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wnps_pkg::WEIGHT_W-1:0]  cfg_data
);
	import wnps_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  busy;

	wnps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.st        (st),
		.cmd       (cmd),
		.busy      (busy)
	);

	wnps_dp #(
		.NODE_SLOTS (NODE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign req_stall = busy;
	assign cfg_ready = 1'b1;

endmodule
